@@ rtl/core/ugsi_pkg.sv @@
// Shared types, constants and codes for the uniform grid spatial index.
package ugsi_pkg;

    localparam int MAX_CELLS = 1024;
    localparam int MAX_NODES = 1024;
    localparam int CELL_AW   = $clog2(MAX_CELLS);
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int LINK_W    = NODE_AW + 1;   // msb set means no node
    localparam int HEAD_W    = NODE_AW + 1;
    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 13;
    localparam int GRID_W    = 6;
    localparam int ELEM_W    = 16;
    localparam int NELEM_W   = 17;
    localparam int CNUM_W    = 10;
    localparam int NNUM_W    = 10;
    localparam int CFG_IW    = 2;
    localparam int CFG_DW    = 13;
    localparam int PROD_W    = 2 * GRID_W + 1;
    localparam int DIV_CW    = $clog2(COORD_W);

    localparam logic [CFG_IW-1:0] REG_CELL_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_CELL_HEIGHT = 2'd1;
    localparam logic [CFG_IW-1:0] REG_GRID_COLS   = 2'd2;
    localparam logic [CFG_IW-1:0] REG_GRID_ROWS   = 2'd3;

    localparam logic [SIZE_W-1:0] CELL_SIZE_RST = 13'd32;
    localparam logic [GRID_W-1:0] GRID_DIM_RST  = 6'd32;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_ERASE     = 2'd1,
        OP_READ_CELL = 2'd2,
        OP_READ_NODE = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_OOB       = 2'd1,
        STS_POOL_FULL = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISP, ST_DIV_LOAD, ST_DIV_RUN, ST_BOUND,
        ST_INS_A, ST_INS_B, ST_ER_A, ST_ER_B, ST_ER_C, ST_ER_D, ST_ER_E,
        ST_QC, ST_QC_W, ST_QN, ST_QN_W, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_CLEAR, CMD_ACCEPT, CMD_DIV_LOAD, CMD_DIV_STEP, CMD_BOUND,
        CMD_INS_ALLOC, CMD_INS_LINK, CMD_ER_START, CMD_ER_HEAD, CMD_ER_MISS,
        CMD_ER_READ, CMD_ER_HIT, CMD_ER_ADV, CMD_ER_FREE, CMD_QC, CMD_QC_CAP,
        CMD_QN, CMD_QN_CAP, CMD_PUSH
    } cmd_t;

    typedef struct packed {
        logic    clr_done;
        opcode_t op;
        logic    div_last;
        logic    div_final;
        logic    oob;
        logic    empty;
        logic    ins_full;
        logic    last_cell;
        logic    er_end;
        logic    er_match;
        logic    qc_oob;
        logic    qn_oob;
        logic    out_free;
    } dp_stat_t;

endpackage

@@ rtl/core/uniform_grid_spatial_index.sv @@
// Uniform grid spatial index: top level joining controller and datapath.
// After reset the block clears every entry of the cell head memory and
// takes no transfer meanwhile; configuration writes are taken at any time the
// block is idle. Items are handled one at a time. Insert and erase first turn
// the four corners into cell coordinates on one shared bit-serial divider,
// after acceptance and dispatch, and then check bounds. Insert then allocates
// a node and links it into each covered cell. Erase walks the list of each
// covered cell, passing over non-matching nodes, and unlinks and frees the
// node where the element is found. Cell-head and node reads skip the memory
// read when out of range. The last cycle of an item waits while the previous
// result is still held in the output register; a new transfer is accepted
// while that result waits.
module uniform_grid_spatial_index (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [12:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [15:0]        s_rect_left,
    input  logic [15:0]        s_rect_top,
    input  logic [15:0]        s_rect_right,
    input  logic [15:0]        s_rect_bottom,
    input  logic [15:0]        s_element_id,
    input  logic [9:0]         s_cell_number,
    input  logic [9:0]         s_node_number,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic               m_head_valid,
    output logic [9:0]         m_head_node,
    output logic signed [16:0] m_node_element,
    output logic               m_next_valid,
    output logic [9:0]         m_next_node
);
    import ugsi_pkg::*;

    cmd_t     cmd;
    dp_stat_t st;

    ugsi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    ugsi_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_opcode       (s_opcode),
        .s_rect_left    (s_rect_left),
        .s_rect_top     (s_rect_top),
        .s_rect_right   (s_rect_right),
        .s_rect_bottom  (s_rect_bottom),
        .s_element_id   (s_element_id),
        .s_cell_number  (s_cell_number),
        .s_node_number  (s_node_number),
        .cmd            (cmd),
        .st             (st),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_head_valid   (m_head_valid),
        .m_head_node    (m_head_node),
        .m_node_element (m_node_element),
        .m_next_valid   (m_next_valid),
        .m_next_node    (m_next_node)
    );

endmodule

@@ rtl/core/ugsi_ctrl.sv @@
// Sequencing state machine for the spatial index.
module ugsi_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ugsi_pkg::dp_stat_t st,
    output ugsi_pkg::cmd_t     cmd
);
    import ugsi_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd = CMD_CLEAR;
                if (st.clr_done) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd        = CMD_ACCEPT;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                case (st.op)
                    OP_INSERT, OP_ERASE: state_next = ST_DIV_LOAD;
                    OP_READ_CELL:        state_next = ST_QC;
                    default:             state_next = ST_QN;
                endcase
            end
            ST_DIV_LOAD: begin
                cmd        = CMD_DIV_LOAD;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                cmd = CMD_DIV_STEP;
                if (st.div_last) state_next = st.div_final ? ST_BOUND : ST_DIV_LOAD;
            end
            ST_BOUND: begin
                cmd = CMD_BOUND;
                if (st.oob || st.empty) state_next = ST_DONE;
                else if (st.op == OP_INSERT) state_next = ST_INS_A;
                else state_next = ST_ER_A;
            end
            ST_INS_A: begin
                cmd        = CMD_INS_ALLOC;
                state_next = st.ins_full ? ST_DONE : ST_INS_B;
            end
            ST_INS_B: begin
                cmd        = CMD_INS_LINK;
                state_next = st.last_cell ? ST_DONE : ST_INS_A;
            end
            ST_ER_A: begin
                cmd        = CMD_ER_START;
                state_next = ST_ER_B;
            end
            ST_ER_B: begin
                cmd        = CMD_ER_HEAD;
                state_next = ST_ER_C;
            end
            ST_ER_C: begin
                if (st.er_end) begin
                    cmd        = CMD_ER_MISS;
                    state_next = st.last_cell ? ST_DONE : ST_ER_A;
                end else begin
                    cmd        = CMD_ER_READ;
                    state_next = ST_ER_D;
                end
            end
            ST_ER_D: begin
                if (st.er_match) begin
                    cmd        = CMD_ER_HIT;
                    state_next = ST_ER_E;
                end else begin
                    cmd        = CMD_ER_ADV;
                    state_next = ST_ER_C;
                end
            end
            ST_ER_E: begin
                cmd        = CMD_ER_FREE;
                state_next = st.last_cell ? ST_DONE : ST_ER_A;
            end
            ST_QC: begin
                cmd        = CMD_QC;
                state_next = st.qc_oob ? ST_DONE : ST_QC_W;
            end
            ST_QC_W: begin
                cmd        = CMD_QC_CAP;
                state_next = ST_DONE;
            end
            ST_QN: begin
                cmd        = CMD_QN;
                state_next = st.qn_oob ? ST_DONE : ST_QN_W;
            end
            ST_QN_W: begin
                cmd        = CMD_QN_CAP;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (st.out_free) begin
                    cmd        = CMD_PUSH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/ugsi_dp.sv @@
// Datapath: registers, shared divider, cell and node memories, result register.
module ugsi_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [ugsi_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [ugsi_pkg::CFG_DW-1:0]   cfg_wdata,
    input  logic [1:0]                    s_opcode,
    input  logic [ugsi_pkg::COORD_W-1:0]  s_rect_left,
    input  logic [ugsi_pkg::COORD_W-1:0]  s_rect_top,
    input  logic [ugsi_pkg::COORD_W-1:0]  s_rect_right,
    input  logic [ugsi_pkg::COORD_W-1:0]  s_rect_bottom,
    input  logic [ugsi_pkg::ELEM_W-1:0]   s_element_id,
    input  logic [ugsi_pkg::CNUM_W-1:0]   s_cell_number,
    input  logic [ugsi_pkg::NNUM_W-1:0]   s_node_number,
    input  ugsi_pkg::cmd_t                cmd,
    output ugsi_pkg::dp_stat_t            st,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_status,
    output logic                          m_head_valid,
    output logic [9:0]                    m_head_node,
    output logic signed [16:0]            m_node_element,
    output logic                          m_next_valid,
    output logic [9:0]                    m_next_node
);
    import ugsi_pkg::*;

    // configuration
    logic [SIZE_W-1:0] cw_reg, ch_reg;
    logic [GRID_W-1:0] cols_reg, rows_reg;

    // control state
    logic [LINK_W-1:0]  free_head_reg;
    logic [NODE_AW:0]   used_reg;
    logic [CELL_AW-1:0] clr_reg;
    logic               m_valid_reg;

    // item
    opcode_t             op_reg;
    logic [COORD_W-1:0]  coord_reg [4];
    logic [ELEM_W-1:0]   elem_reg;
    logic [CNUM_W-1:0]   cnum_reg;
    logic [NNUM_W-1:0]   nnum_reg;

    // divider
    logic [1:0]          sel_reg;
    logic [DIV_CW-1:0]   dcnt_reg;
    logic [COORD_W-1:0]  dvd_reg;
    logic [SIZE_W-1:0]   rem_reg;
    logic [COORD_W-1:0]  q_reg [4];

    // cell walk
    logic [GRID_W-1:0]   x_reg, y_reg;
    logic [CELL_AW-1:0]  rowbase_reg;
    logic [NODE_AW-1:0]  node_reg;
    logic                from_free_reg;
    logic [LINK_W-1:0]   cur_reg, prev_reg;
    logic [NODE_AW:0]    steps_reg;

    // result
    status_t             res_status_reg;
    logic                res_hv_reg, res_nv_reg;
    logic [9:0]          res_hn_reg, res_nn_reg;
    logic [NELEM_W-1:0]  res_el_reg;
    status_t             m_status_reg;
    logic                m_hv_reg, m_nv_reg;
    logic [9:0]          m_hn_reg, m_nn_reg;
    logic [NELEM_W-1:0]  m_el_reg;

    // memories
    logic [HEAD_W-1:0]   ch_mem [MAX_CELLS];
    logic [NELEM_W-1:0]  el_mem [MAX_NODES];
    logic [LINK_W-1:0]   lk_mem [MAX_NODES];
    logic [HEAD_W-1:0]   ch_rdata;
    logic [NELEM_W-1:0]  el_rdata;
    logic [LINK_W-1:0]   lk_rdata;
    logic                ch_we, ch_re, el_we, el_re, lk_we, lk_re;
    logic [CELL_AW-1:0]  ch_waddr, ch_raddr;
    logic [NODE_AW-1:0]  el_waddr, el_raddr, lk_waddr, lk_raddr;
    logic [HEAD_W-1:0]   ch_wdata;
    logic [NELEM_W-1:0]  el_wdata;
    logic [LINK_W-1:0]   lk_wdata;

    // combinational helpers
    logic [SIZE_W-1:0]   divisor;
    logic [SIZE_W:0]     trial;
    logic                qbit;
    logic [SIZE_W-1:0]   rem_new;
    logic [PROD_W-1:0]   last_idx, grid_cells;
    logic [2*GRID_W-1:0] row_start;
    logic [CELL_AW-1:0]  cell_idx;
    logic                free_nil, advance;

    assign divisor  = sel_reg[0] ? ((ch_reg == '0) ? SIZE_W'(1) : ch_reg)
                                 : ((cw_reg == '0) ? SIZE_W'(1) : cw_reg);
    assign trial    = {rem_reg, dvd_reg[COORD_W-1]};
    assign qbit     = (trial >= {1'b0, divisor});
    assign rem_new  = qbit ? SIZE_W'(trial - {1'b0, divisor}) : trial[SIZE_W-1:0];
    assign last_idx = PROD_W'(q_reg[3][GRID_W-1:0] * cols_reg) + PROD_W'(q_reg[2][GRID_W-1:0]);
    assign row_start  = q_reg[1][GRID_W-1:0] * cols_reg;
    assign grid_cells = PROD_W'(cols_reg * rows_reg);
    assign cell_idx = rowbase_reg + CELL_AW'(x_reg);
    assign free_nil = free_head_reg[NODE_AW];
    assign advance  = (cmd == CMD_INS_LINK) || (cmd == CMD_ER_MISS) || (cmd == CMD_ER_FREE);

    always_comb begin
        st.clr_done  = (clr_reg == CELL_AW'(MAX_CELLS - 1));
        st.op        = op_reg;
        st.div_last  = (dcnt_reg == DIV_CW'(COORD_W - 1));
        st.div_final = (sel_reg == 2'd3);
        st.oob       = (q_reg[2] >= COORD_W'(cols_reg)) || (q_reg[3] >= COORD_W'(rows_reg))
                       || (32'(last_idx) >= 32'(MAX_CELLS));
        st.empty     = (q_reg[0] > q_reg[2]) || (q_reg[1] > q_reg[3]);
        st.ins_full  = free_nil && (used_reg == (NODE_AW+1)'(MAX_NODES));
        st.last_cell = (x_reg == q_reg[2][GRID_W-1:0]) && (y_reg == q_reg[3][GRID_W-1:0]);
        st.er_end    = cur_reg[NODE_AW] || (steps_reg == (NODE_AW+1)'(MAX_NODES));
        st.er_match  = (el_rdata == {1'b0, elem_reg});
        st.qc_oob    = (PROD_W'(cnum_reg) >= grid_cells) || (32'(cnum_reg) >= 32'(MAX_CELLS));
        st.qn_oob    = (32'(nnum_reg) >= 32'(used_reg)) || (32'(nnum_reg) >= 32'(MAX_NODES));
        st.out_free  = !m_valid_reg || m_ready;
    end

    // memory port steering
    always_comb begin
        ch_we = 1'b0; ch_waddr = cell_idx; ch_wdata = {1'b0, node_reg};
        ch_re = 1'b0; ch_raddr = cell_idx;
        el_we = 1'b0; el_waddr = node_reg; el_wdata = {1'b0, elem_reg};
        el_re = 1'b0; el_raddr = cur_reg[NODE_AW-1:0];
        lk_we = 1'b0; lk_waddr = node_reg; lk_wdata = ch_rdata;
        lk_re = 1'b0; lk_raddr = cur_reg[NODE_AW-1:0];
        case (cmd)
            CMD_CLEAR: begin
                ch_we = 1'b1; ch_waddr = clr_reg; ch_wdata = {1'b1, {NODE_AW{1'b0}}};
            end
            CMD_INS_ALLOC: begin
                ch_re = 1'b1;
                lk_re = !free_nil; lk_raddr = free_head_reg[NODE_AW-1:0];
            end
            CMD_INS_LINK: begin
                ch_we = 1'b1; el_we = 1'b1; lk_we = 1'b1;
                ch_wdata = {1'b0, node_reg};
            end
            CMD_ER_START: ch_re = 1'b1;
            CMD_ER_READ: begin
                el_re = 1'b1; lk_re = 1'b1;
            end
            CMD_ER_HIT: begin
                if (prev_reg[NODE_AW]) begin
                    ch_we = 1'b1; ch_wdata = lk_rdata;
                end else begin
                    lk_we = 1'b1; lk_waddr = prev_reg[NODE_AW-1:0]; lk_wdata = lk_rdata;
                end
            end
            CMD_ER_FREE: begin
                lk_we = 1'b1; lk_waddr = cur_reg[NODE_AW-1:0]; lk_wdata = free_head_reg;
                el_we = 1'b1; el_waddr = cur_reg[NODE_AW-1:0]; el_wdata = '1;
            end
            CMD_QC: begin
                ch_re = !st.qc_oob; ch_raddr = CELL_AW'(cnum_reg);
            end
            CMD_QN: begin
                el_re = !st.qn_oob; el_raddr = NODE_AW'(nnum_reg);
                lk_re = !st.qn_oob; lk_raddr = NODE_AW'(nnum_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ch_we) ch_mem[ch_waddr] <= ch_wdata;
        if (ch_re) ch_rdata <= ch_mem[ch_raddr];
    end

    always_ff @(posedge aclk) begin
        if (el_we) el_mem[el_waddr] <= el_wdata;
        if (el_re) el_rdata <= el_mem[el_raddr];
    end

    always_ff @(posedge aclk) begin
        if (lk_we) lk_mem[lk_waddr] <= lk_wdata;
        if (lk_re) lk_rdata <= lk_mem[lk_raddr];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg        <= CELL_SIZE_RST;
            ch_reg        <= CELL_SIZE_RST;
            cols_reg      <= GRID_DIM_RST;
            rows_reg      <= GRID_DIM_RST;
            free_head_reg <= {1'b1, {NODE_AW{1'b0}}};
            used_reg      <= '0;
            clr_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CELL_WIDTH:  cw_reg   <= cfg_wdata;
                    REG_CELL_HEIGHT: ch_reg   <= cfg_wdata;
                    REG_GRID_COLS:   cols_reg <= cfg_wdata[GRID_W-1:0];
                    REG_GRID_ROWS:   rows_reg <= cfg_wdata[GRID_W-1:0];
                    default: begin
                    end
                endcase
            end
            case (cmd)
                CMD_CLEAR: clr_reg <= clr_reg + 1'b1;
                CMD_INS_ALLOC: begin
                    if (free_nil && !st.ins_full) used_reg <= used_reg + 1'b1;
                end
                CMD_INS_LINK: begin
                    if (from_free_reg) free_head_reg <= lk_rdata;
                end
                CMD_ER_FREE: free_head_reg <= cur_reg;
                default: begin
                end
            endcase
            if (cmd == CMD_PUSH) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // item, walk and result registers
    always_ff @(posedge aclk) begin
        case (cmd)
            CMD_ACCEPT: begin
                op_reg         <= opcode_t'(s_opcode);
                coord_reg[0]   <= s_rect_left;
                coord_reg[1]   <= s_rect_top;
                coord_reg[2]   <= s_rect_right;
                coord_reg[3]   <= s_rect_bottom;
                elem_reg       <= s_element_id;
                cnum_reg       <= s_cell_number;
                nnum_reg       <= s_node_number;
                sel_reg        <= '0;
                res_status_reg <= STS_OK;
                res_hv_reg     <= 1'b0;
                res_hn_reg     <= '0;
                res_el_reg     <= '0;
                res_nv_reg     <= 1'b0;
                res_nn_reg     <= '0;
            end
            CMD_DIV_LOAD: begin
                dvd_reg  <= coord_reg[sel_reg];
                rem_reg  <= '0;
                dcnt_reg <= '0;
            end
            CMD_DIV_STEP: begin
                dvd_reg  <= {dvd_reg[COORD_W-2:0], qbit};
                rem_reg  <= rem_new;
                dcnt_reg <= dcnt_reg + 1'b1;
                if (st.div_last) begin
                    q_reg[sel_reg] <= {dvd_reg[COORD_W-2:0], qbit};
                    sel_reg        <= sel_reg + 1'b1;
                end
            end
            CMD_BOUND: begin
                if (st.oob) res_status_reg <= STS_OOB;
                x_reg       <= q_reg[0][GRID_W-1:0];
                y_reg       <= q_reg[1][GRID_W-1:0];
                rowbase_reg <= CELL_AW'(row_start);
            end
            CMD_INS_ALLOC: begin
                if (st.ins_full) res_status_reg <= STS_POOL_FULL;
                node_reg      <= free_nil ? used_reg[NODE_AW-1:0] : free_head_reg[NODE_AW-1:0];
                from_free_reg <= !free_nil;
            end
            CMD_ER_START: begin
                prev_reg  <= {1'b1, {NODE_AW{1'b0}}};
                steps_reg <= '0;
            end
            CMD_ER_HEAD: cur_reg <= ch_rdata;
            CMD_ER_MISS: res_status_reg <= STS_NOT_FOUND;
            CMD_ER_ADV: begin
                prev_reg  <= cur_reg;
                cur_reg   <= lk_rdata;
                steps_reg <= steps_reg + 1'b1;
            end
            CMD_QC: begin
                if (st.qc_oob) res_status_reg <= STS_OOB;
            end
            CMD_QC_CAP: begin
                res_hv_reg <= !ch_rdata[NODE_AW];
                res_hn_reg <= ch_rdata[NODE_AW] ? 10'd0 : 10'(ch_rdata[NODE_AW-1:0]);
            end
            CMD_QN: begin
                if (st.qn_oob) res_status_reg <= STS_OOB;
            end
            CMD_QN_CAP: begin
                res_el_reg <= el_rdata;
                res_nv_reg <= !lk_rdata[NODE_AW];
                res_nn_reg <= lk_rdata[NODE_AW] ? 10'd0 : 10'(lk_rdata[NODE_AW-1:0]);
            end
            CMD_PUSH: begin
                m_status_reg <= res_status_reg;
                m_hv_reg     <= res_hv_reg;
                m_hn_reg     <= res_hn_reg;
                m_el_reg     <= res_el_reg;
                m_nv_reg     <= res_nv_reg;
                m_nn_reg     <= res_nn_reg;
            end
            default: begin
            end
        endcase
        if (advance) begin
            if (x_reg == q_reg[2][GRID_W-1:0]) begin
                x_reg       <= q_reg[0][GRID_W-1:0];
                y_reg       <= y_reg + 1'b1;
                rowbase_reg <= rowbase_reg + CELL_AW'(cols_reg);
            end else begin
                x_reg <= x_reg + 1'b1;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_head_valid   = m_hv_reg;
    assign m_head_node    = m_hn_reg;
    assign m_node_element = m_el_reg;
    assign m_next_valid   = m_nv_reg;
    assign m_next_node    = m_nn_reg;

endmodule

@@ rtl/core/ugsi_chk.sv @@
// Port-level assertion checker for the spatial index, bound to the top level.
module ugsi_chk (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic               m_head_valid,
    input logic [9:0]         m_head_node,
    input logic signed [16:0] m_node_element,
    input logic               m_next_valid,
    input logic [9:0]         m_next_node
);
    import ugsi_pkg::*;

    // a stalled result holds its status and node element
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_node_element))
        else $error("result changed while stalled");

    // one item at a time: no transfer in the cycle after one
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken twice in a row");

    // failed operations carry nothing but the status
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STS_OK) |->
            !m_head_valid && !m_next_valid && (m_head_node == '0)
            && (m_next_node == '0) && (m_node_element == '0))
        else $error("payload set on failed operation");

    // a cell-head result never carries node fields
    a_head_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_head_valid |-> !m_next_valid && (m_node_element == '0)
            && (m_next_node == '0))
        else $error("mixed result fields");

endmodule

bind uniform_grid_spatial_index ugsi_chk u_chk (.*);

@@ tb/tb_uniform_grid_spatial_index.sv @@
// Self-checking testbench for the uniform grid spatial index: queued stimulus, clocked driver and monitor.
`timescale 1ns / 100ps

module tb_uniform_grid_spatial_index;
    import ugsi_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int NIL = -1;

    typedef struct packed {
        opcode_t          op;
        logic [15:0]      left;
        logic [15:0]      top;
        logic [15:0]      right;
        logic [15:0]      bottom;
        logic [15:0]      elem;
        logic [9:0]       cnum;
        logic [9:0]       node;
    } item_t;

    typedef struct packed {
        status_t            status;
        logic               head_valid;
        logic [9:0]         head_node;
        logic signed [16:0] node_element;
        logic               next_valid;
        logic [9:0]         succ_node;
    } answer_t;

    typedef struct {
        int l;
        int t;
        int r;
        int b;
        int id;
    } placed_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [12:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_opcode;
    logic [15:0]        s_rect_left;
    logic [15:0]        s_rect_top;
    logic [15:0]        s_rect_right;
    logic [15:0]        s_rect_bottom;
    logic [15:0]        s_element_id;
    logic [9:0]         s_cell_number;
    logic [9:0]         s_node_number;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic               m_head_valid;
    logic [9:0]         m_head_node;
    logic signed [16:0] m_node_element;
    logic               m_next_valid;
    logic [9:0]         m_next_node;

    uniform_grid_spatial_index dut (.*);

    // grid settings, shared by stimulus and predictor (changed only when idle)
    int cw = 32, ch = 32, cols = 32, rows = 32;

    // mirror of the index
    int cell_list[MAX_CELLS];
    int node_elem[MAX_NODES];
    int node_link[MAX_NODES];
    int free_list;
    int nodes_used;

    item_t   pending[$];
    answer_t answers[$];
    placed_t placed[$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    function automatic void queue_item(item_t it);
        pending.insert(pending.size(), it);
    endfunction

    function automatic int take_node();
        int n;
        if (free_list != NIL) begin
            n = free_list;
            free_list = node_link[n];
            return n;
        end
        if (nodes_used >= MAX_NODES) return NIL;
        nodes_used++;
        return nodes_used - 1;
    endfunction

    function automatic bit unlink_elem(int c, int e);
        int prev, cur, steps, nx;
        prev = NIL;
        cur = cell_list[c];
        steps = 0;
        while (cur != NIL && steps < MAX_NODES) begin
            if (node_elem[cur] == e) begin
                nx = node_link[cur];
                if (prev == NIL) cell_list[c] = nx;
                else node_link[prev] = nx;
                node_link[cur] = free_list;
                free_list = cur;
                node_elem[cur] = -1;
                return 1'b1;
            end
            prev = cur;
            cur = node_link[cur];
            steps++;
        end
        return 1'b0;
    endfunction

    function automatic status_t apply_rect(item_t it);
        int unsigned w, h, x1, y1, x2, y2, c;
        int n;
        status_t st;
        w = (cw == 0) ? 1 : cw;
        h = (ch == 0) ? 1 : ch;
        x1 = it.left / w;
        y1 = it.top / h;
        x2 = it.right / w;
        y2 = it.bottom / h;
        st = STS_OK;
        if (x2 >= cols || y2 >= rows || y2 * cols + x2 >= MAX_CELLS) return STS_OOB;
        for (int unsigned y = y1; y <= y2; y++) begin
            for (int unsigned x = x1; x <= x2; x++) begin
                c = y * cols + x;
                if (it.op == OP_INSERT) begin
                    n = take_node();
                    if (n == NIL) return STS_POOL_FULL;
                    node_elem[n] = it.elem;
                    node_link[n] = cell_list[c];
                    cell_list[c] = n;
                end else if (!unlink_elem(c, it.elem)) begin
                    st = STS_NOT_FOUND;
                end
            end
        end
        return st;
    endfunction

    function automatic answer_t predict_answer(item_t it);
        answer_t a;
        a = '0;
        case (it.op)
            OP_INSERT, OP_ERASE: a.status = apply_rect(it);
            OP_READ_CELL: begin
                if (it.cnum >= cols * rows || it.cnum >= MAX_CELLS) a.status = STS_OOB;
                else if (cell_list[it.cnum] != NIL) begin
                    a.head_valid = 1'b1;
                    a.head_node = 10'(cell_list[it.cnum]);
                end
            end
            default: begin
                if (it.node >= nodes_used) a.status = STS_OOB;
                else begin
                    a.node_element = 17'(node_elem[it.node]);
                    if (node_link[it.node] != NIL) begin
                        a.next_valid = 1'b1;
                        a.succ_node = 10'(node_link[it.node]);
                    end
                end
            end
        endcase
        return a;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid       <= 1'b0;
            s_opcode      <= '0;
            s_rect_left   <= '0;
            s_rect_top    <= '0;
            s_rect_right  <= '0;
            s_rect_bottom <= '0;
            s_element_id  <= '0;
            s_cell_number <= '0;
            s_node_number <= '0;
        end else if (!s_valid || s_ready) begin
            if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                item_t it;
                it = pending.pop_front();
                s_valid       <= 1'b1;
                s_opcode      <= it.op;
                s_rect_left   <= it.left;
                s_rect_top    <= it.top;
                s_rect_right  <= it.right;
                s_rect_bottom <= it.bottom;
                s_element_id  <= it.elem;
                s_cell_number <= it.cnum;
                s_node_number <= it.node;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor, predictor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (answers.size() == 0) begin
                    $display("%0t: result transfer with none expected, status %0d",
                             $time, m_status);
                    errors++;
                end else begin
                    answer_t e;
                    e = answers.pop_front();
                    if (m_status !== e.status) begin
                        $display("%0t: status exp %0d got %0d", $time, e.status, m_status);
                        errors++;
                    end
                    if (m_head_valid !== e.head_valid) begin
                        $display("%0t: head_valid exp %0d got %0d", $time, e.head_valid,
                                 m_head_valid);
                        errors++;
                    end
                    if (m_head_node !== e.head_node) begin
                        $display("%0t: head_node exp %0d got %0d", $time, e.head_node,
                                 m_head_node);
                        errors++;
                    end
                    if (m_node_element !== e.node_element) begin
                        $display("%0t: node_element exp %0d got %0d", $time, e.node_element,
                                 m_node_element);
                        errors++;
                    end
                    if (m_next_valid !== e.next_valid) begin
                        $display("%0t: next_valid exp %0d got %0d", $time, e.next_valid,
                                 m_next_valid);
                        errors++;
                    end
                    if (m_next_node !== e.succ_node) begin
                        $display("%0t: successor exp %0d got %0d", $time, e.succ_node,
                                 m_next_node);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                item_t it;
                it.op = opcode_t'(s_opcode);
                it.left = s_rect_left;
                it.top = s_rect_top;
                it.right = s_rect_right;
                it.bottom = s_rect_bottom;
                it.elem = s_element_id;
                it.cnum = s_cell_number;
                it.node = s_node_number;
                answers.insert(answers.size(), predict_answer(it));
            end
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic item_t make_rect(opcode_t op, int l, int t, int r, int b, int id);
        item_t it;
        it.op = op;
        it.left = 16'(l);
        it.top = 16'(t);
        it.right = 16'(r);
        it.bottom = 16'(b);
        it.elem = 16'(id);
        it.cnum = 10'($urandom);
        it.node = 10'($urandom);
        return it;
    endfunction

    function automatic item_t make_read(opcode_t op, int idx);
        item_t it;
        it = make_rect(op, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (op == OP_READ_CELL) it.cnum = 10'(idx);
        else it.node = 10'(idx);
        return it;
    endfunction

    task automatic add_random(int count);
        int w, h, x, y, sx, sy, k, pick;
        placed_t p;
        w = (cw == 0) ? 1 : cw;
        h = (ch == 0) ? 1 : ch;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                if ($urandom_range(9) == 0) begin
                    queue_item(make_rect(OP_INSERT, $urandom, $urandom, $urandom,
                                         $urandom, $urandom));
                end else begin
                    x = $urandom_range(cols > 0 ? cols - 1 : 0);
                    y = $urandom_range(rows > 0 ? rows - 1 : 0);
                    sx = $urandom_range(1);
                    sy = $urandom_range(1);
                    p.l = (x * w + $urandom_range(w - 1)) & 16'hFFFF;
                    p.t = (y * h + $urandom_range(h - 1)) & 16'hFFFF;
                    p.r = ((x + sx) * w + $urandom_range(w - 1)) & 16'hFFFF;
                    p.b = ((y + sy) * h + $urandom_range(h - 1)) & 16'hFFFF;
                    p.id = $urandom_range(16'hFFFF);
                    placed.insert(placed.size(), p);
                    queue_item(make_rect(OP_INSERT, p.l, p.t, p.r, p.b, p.id));
                end
            end else if (pick < 65) begin
                if (placed.size() > 0 && $urandom_range(4) != 0) begin
                    k = $urandom_range(placed.size() - 1);
                    p = placed[k];
                    placed.delete(k);
                    queue_item(make_rect(OP_ERASE, p.l, p.t, p.r, p.b, p.id));
                end else begin
                    queue_item(make_rect(OP_ERASE, $urandom_range(3 * w),
                                         $urandom_range(3 * h), $urandom_range(3 * w),
                                         $urandom_range(3 * h), $urandom));
                end
            end else if (pick < 85) begin
                if ($urandom_range(4) == 0) queue_item(make_read(OP_READ_CELL, $urandom));
                else queue_item(make_read(OP_READ_CELL,
                                          $urandom_range(cols * rows > 0 ?
                                                         cols * rows - 1 : 0)));
            end else begin
                if ($urandom_range(3) == 0) queue_item(make_read(OP_READ_NODE, $urandom));
                else queue_item(make_read(OP_READ_NODE, $urandom_range(255)));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending.size() > 0 || s_valid || answers.size() > 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_grid(int w, int h, int c, int r);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= REG_CELL_WIDTH;
        cfg_wdata <= 13'(w);
        @(posedge aclk);
        cfg_index <= REG_CELL_HEIGHT;
        cfg_wdata <= 13'(h);
        @(posedge aclk);
        cfg_index <= REG_GRID_COLS;
        cfg_wdata <= 13'(c);
        @(posedge aclk);
        cfg_index <= REG_GRID_ROWS;
        cfg_wdata <= 13'(r);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cw = w & 13'h1FFF;
        ch = h & 13'h1FFF;
        cols = c & 6'h3F;
        rows = r & 6'h3F;
        placed.delete();
    endtask

    initial begin
        for (int i = 0; i < MAX_CELLS; i++) cell_list[i] = NIL;
        for (int i = 0; i < MAX_NODES; i++) begin
            node_elem[i] = 0;
            node_link[i] = NIL;
        end
        free_list = NIL;
        nodes_used = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed checks at reset geometry
        queue_item(make_rect(OP_INSERT, 0, 0, 0, 0, 0));
        queue_item(make_rect(OP_INSERT, 10, 10, 40, 40, 16'hFFFF));
        queue_item(make_read(OP_READ_CELL, 0));
        queue_item(make_read(OP_READ_CELL, 33));
        queue_item(make_read(OP_READ_NODE, 0));
        queue_item(make_read(OP_READ_NODE, 1));
        queue_item(make_read(OP_READ_NODE, 1023));
        queue_item(make_rect(OP_INSERT, 992, 992, 1023, 1023, 7));
        queue_item(make_read(OP_READ_CELL, 1023));
        queue_item(make_rect(OP_INSERT, 0, 0, 1024, 5, 8));
        queue_item(make_rect(OP_INSERT, 5, 0, 5, 1024, 8));
        queue_item(make_rect(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 9));
        queue_item(make_rect(OP_INSERT, 50, 50, 10, 60, 9));
        queue_item(make_rect(OP_ERASE, 60, 50, 60, 10, 9));
        queue_item(make_rect(OP_ERASE, 0, 0, 0, 0, 1234));
        queue_item(make_rect(OP_ERASE, 0, 0, 0, 0, 0));
        queue_item(make_read(OP_READ_NODE, 0));
        queue_item(make_rect(OP_ERASE, 0, 0, 100, 40, 16'hFFFF));
        queue_item(make_read(OP_READ_NODE, 2));
        queue_item(make_rect(OP_INSERT, 64, 64, 64, 64, 3));
        queue_item(make_read(OP_READ_CELL, 66));
        queue_item(make_read(OP_READ_NODE, 4));
        add_random(380);
        wait_idle();

        set_grid(1, 4096, 32, 1);
        send_idle_pct = 70;
        add_random(400);
        wait_idle();

        set_grid(4096, 1, 1, 32);
        send_idle_pct = 0;
        recv_stall_pct = 70;
        add_random(400);
        wait_idle();

        // zero cell size and wide register values
        set_grid(0, 8191, 63, 17);
        send_idle_pct = 38;
        recv_stall_pct = 38;
        add_random(400);
        wait_idle();

        set_grid(7, 13, 32, 32);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 3000;
        add_random(400);
        wait_idle();

        // pool exhaustion and recovery through the free list
        set_grid(32, 32, 32, 32);
        queue_item(make_rect(OP_INSERT, 0, 0, 1023, 1023, 500));
        queue_item(make_rect(OP_INSERT, 0, 0, 1023, 1023, 501));
        queue_item(make_read(OP_READ_NODE, 1023));
        queue_item(make_rect(OP_ERASE, 0, 0, 1023, 1023, 501));
        queue_item(make_rect(OP_ERASE, 0, 0, 95, 95, 500));
        queue_item(make_rect(OP_INSERT, 0, 0, 1023, 63, 502));
        queue_item(make_read(OP_READ_CELL, 0));
        queue_item(make_read(OP_READ_NODE, 512));
        add_random(60);
        wait_idle();
        repeat (50) @(posedge aclk);

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ugsi_pkg.sv
rtl/core/ugsi_ctrl.sv
rtl/core/ugsi_dp.sv
rtl/core/uniform_grid_spatial_index.sv
rtl/core/ugsi_chk.sv
tb/tb_uniform_grid_spatial_index.sv
